>>> design/b64d_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and the character classifier for the base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

	localparam int CMD_DEPTH = 4;
	localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
	localparam int CMD_CNT_W = CMD_PTR_W + 1;

	localparam logic [7:0] CH_PAD   = 8'h3D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_Z  = 8'h7A;
	localparam logic [7:0] CH_DIG_0 = 8'h30;
	localparam logic [7:0] CH_DIG_9 = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;

	localparam logic [5:0] SEXT_LO_BASE  = 6'd26;
	localparam logic [5:0] SEXT_DIG_BASE = 6'd52;
	localparam logic [5:0] SEXT_PLUS     = 6'd62;
	localparam logic [5:0] SEXT_SLASH    = 6'd63;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_CHAR = 2'd1,
		ST_BAD_LEN  = 2'd2
	} status_t;

	// One request for the back end: a decoded group and the bytes to send.
	typedef struct packed {
		logic [23:0] word;
		logic [2:0]  mask;
		logic        last;
		status_t     status;
	} cmd_t;

	typedef struct packed {
		logic is_invalid;
		logic [5:0] value;
	} sextet_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic sextet_t sextet_of(input logic [7:0] c);
		sextet_t r;
		logic [7:0] d;
		r.is_invalid = 1'b0;
		r.value = '0;
		d = '0;
		if (c >= CH_UP_A && c <= CH_UP_Z) begin
			d = c - CH_UP_A;
			r.value = d[5:0];
		end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
			d = c - CH_LO_A;
			r.value = d[5:0] + SEXT_LO_BASE;
		end else if (c >= CH_DIG_0 && c <= CH_DIG_9) begin
			d = c - CH_DIG_0;
			r.value = d[5:0] + SEXT_DIG_BASE;
		end else if (c == CH_PLUS) begin
			r.value = SEXT_PLUS;
		end else if (c == CH_SLASH) begin
			r.value = SEXT_SLASH;
		end else begin
			r.is_invalid = 1'b1;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> design/b64d_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, classifies them and gathers groups of four sextets.
// ----------------------------------------------------------------------------
module b64d_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_push,
	input  wire logic [7:0]      in_char,
	input  wire logic            in_eot,
	input  wire logic            cmd_full,
	output logic                 cmd_push,
	output b64d_pkg::cmd_t       cmd
);

	logic [17:0]       held_q, held_n;
	logic              third_pad_q, third_pad_n;
	logic [1:0]        count_q, count_n;
	logic              err_q, err_n;
	logic              accept;
	logic              space;
	logic              pad;
	logic              pad_ok;
	b64d_pkg::sextet_t sx;
	logic [5:0]        v;
	logic [2:0]        mask;

	assign accept = in_push && !cmd_full;
	assign space  = b64d_pkg::is_space(in_char);
	assign pad    = (in_char == b64d_pkg::CH_PAD);
	assign pad_ok = pad && count_q[1];
	assign sx     = b64d_pkg::sextet_of(in_char);
	assign v      = (pad_ok || sx.is_invalid) ? 6'd0 : sx.value;

	always_comb begin
		held_n      = held_q;
		third_pad_n = third_pad_q;
		count_n     = count_q;
		err_n       = err_q;
		mask        = 3'b000;
		if (!space) begin
			if (!pad_ok && sx.is_invalid) begin
				err_n = 1'b1;
			end
			if (count_q != 2'd3) begin
				held_n  = {held_q[11:0], v};
				count_n = count_q + 2'd1;
				if (count_q == 2'd2) begin
					third_pad_n = pad;
				end
			end else begin
				count_n     = 2'd0;
				held_n      = '0;
				third_pad_n = 1'b0;
				if (!err_n) begin
					mask = {1'b1, !third_pad_q, !pad};
				end
			end
		end
	end

	always_comb begin
		cmd.word = {held_q, v};
		cmd.mask = mask;
		cmd.last = in_eot;
		if (count_n != 2'd0) begin
			cmd.status = b64d_pkg::ST_BAD_LEN;
		end else if (err_n) begin
			cmd.status = b64d_pkg::ST_BAD_CHAR;
		end else begin
			cmd.status = b64d_pkg::ST_OK;
		end
		cmd_push = accept && ((mask != 3'b000) || in_eot);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= '0;
			third_pad_q <= 1'b0;
			count_q     <= '0;
			err_q       <= 1'b0;
		end else if (accept) begin
			if (in_eot) begin
				held_q      <= '0;
				third_pad_q <= 1'b0;
				count_q     <= '0;
				err_q       <= 1'b0;
			end else begin
				held_q      <= held_n;
				third_pad_q <= third_pad_n;
				count_q     <= count_n;
				err_q       <= err_n;
			end
		end
	end

endmodule
`default_nettype wire

>>> design/b64d_cmd_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_cmd_fifo
// Short show-ahead queue of requests between the front and the back end.
// ----------------------------------------------------------------------------
module b64d_cmd_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            wr_en,
	input  wire b64d_pkg::cmd_t  wr_data,
	output logic                 full,
	input  wire logic            rd_en,
	output logic                 rd_valid,
	output b64d_pkg::cmd_t       rd_data
);

	b64d_pkg::cmd_t                   mem_q [b64d_pkg::CMD_DEPTH];
	logic [b64d_pkg::CMD_PTR_W-1:0]   wr_ptr_q;
	logic [b64d_pkg::CMD_PTR_W-1:0]   rd_ptr_q;
	logic [b64d_pkg::CMD_CNT_W-1:0]   count_q;
	logic                             do_wr;
	logic                             do_rd;

	assign full     = (count_q == b64d_pkg::CMD_CNT_W'(b64d_pkg::CMD_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

>>> design/b64d_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_back
// Splits each request into its result bytes and holds them in an output stage.
// ----------------------------------------------------------------------------
module b64d_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cmd_valid,
	input  wire b64d_pkg::cmd_t  cmd,
	output logic                 cmd_pop,
	output logic                 empty,
	input  wire logic            pop,
	output logic [7:0]           data_byte,
	output logic                 byte_valid,
	output logic                 last_result,
	output logic [1:0]           status
);

	logic [2:0]       sent_q;
	logic             out_valid_q;
	logic [7:0]       data_q;
	logic             bvalid_q;
	logic             last_q;
	b64d_pkg::status_t status_q;
	logic [2:0]       rem;
	logic [2:0]       pick;
	logic             is_final;
	logic             load;
	logic [7:0]       sel_byte;

	assign rem      = cmd.mask & ~sent_q;
	assign pick     = {rem[2], rem[1] & !rem[2], rem[0] & !rem[2] & !rem[1]};
	assign is_final = ((rem & ~pick) == 3'b000);
	assign load     = cmd_valid && (!out_valid_q || pop);
	assign cmd_pop  = load && is_final;

	always_comb begin
		if (pick[2]) begin
			sel_byte = cmd.word[23:16];
		end else if (pick[1]) begin
			sel_byte = cmd.word[15:8];
		end else if (pick[0]) begin
			sel_byte = cmd.word[7:0];
		end else begin
			sel_byte = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				sent_q      <= is_final ? 3'b000 : (sent_q | pick);
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q   <= sel_byte;
			bvalid_q <= |pick;
			last_q   <= cmd.last && is_final;
			status_q <= (cmd.last && is_final) ? cmd.status : b64d_pkg::ST_OK;
		end
	end

	assign empty       = !out_valid_q;
	assign data_byte   = data_q;
	assign byte_valid  = bvalid_q;
	assign last_result = last_q;
	assign status      = status_q;

endmodule
`default_nettype wire

>>> design/base64_decoder_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// base64_decoder_core
// Streaming base64 decoder: one character in, decoded bytes and status out.
// ----------------------------------------------------------------------------
// Path: a character's first result passes through the request queue and then
// the output stage before it shows on the result ports.
// Throughput: one character per cycle and one result per cycle while results
// are popped; the front stalls only when the four-entry request queue is full.
// Reset clears the group state, the queue and the output stage at once.
module base64_decoder_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic [7:0] char_code,
	input  wire logic       end_of_text,
	output logic            empty,
	input  wire logic       pop,
	output logic [7:0]      data_byte,
	output logic            byte_valid,
	output logic            last_result,
	output logic [1:0]      status
);

	logic           fe_push;
	b64d_pkg::cmd_t fe_cmd;
	logic           q_valid;
	b64d_pkg::cmd_t q_cmd;
	logic           q_pop;

	b64d_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_push  (push),
		.in_char  (char_code),
		.in_eot   (end_of_text),
		.cmd_full (full),
		.cmd_push (fe_push),
		.cmd      (fe_cmd)
	);

	b64d_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (fe_push),
		.wr_data  (fe_cmd),
		.full     (full),
		.rd_en    (q_pop),
		.rd_valid (q_valid),
		.rd_data  (q_cmd)
	);

	b64d_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (q_valid),
		.cmd         (q_cmd),
		.cmd_pop     (q_pop),
		.empty       (empty),
		.pop         (pop),
		.data_byte   (data_byte),
		.byte_valid  (byte_valid),
		.last_result (last_result),
		.status      (status)
	);

endmodule
`default_nettype wire

>>> design/b64d_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_checker
// Port-level checks for the base64 decoder, bound to the top level.
// ----------------------------------------------------------------------------
module b64d_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       empty,
	input wire logic       pop,
	input wire logic [7:0] data_byte,
	input wire logic       byte_valid,
	input wire logic       last_result,
	input wire logic [1:0] status
);

	// A result without a byte is only ever the closing status of a text.
	a_status_only_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !byte_valid) |-> last_result)
		else $error("status-only result without last_result");

	a_status_only_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !byte_valid) |-> (data_byte == 8'd0))
		else $error("status-only result with nonzero data");

	a_status_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !last_result) |-> (status == b64d_pkg::ST_OK))
		else $error("nonzero status on a result that is not final");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (status <= b64d_pkg::ST_BAD_LEN))
		else $error("undefined status code");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(data_byte) && $stable(last_result)))
		else $error("waiting result changed");

endmodule

bind base64_decoder_core b64d_checker u_b64d_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.empty       (empty),
	.pop         (pop),
	.data_byte   (data_byte),
	.byte_valid  (byte_valid),
	.last_result (last_result),
	.status      (status)
);
`default_nettype wire
